[rtl/core/mecanum_wheel_mixer_macros.svh]
// ----------------------------------------------------------------------------
// mecanum wheel mixer assertion macros
// same-cycle and next-cycle implication checks, reset gated
// ----------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_MIXER_MACROS_SVH
`define MECANUM_WHEEL_MIXER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MWM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MWM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mwm_pkg.sv]
// ----------------------------------------------------------------------------
// mwm_pkg
// shared widths, register codes and word types of the mecanum wheel mixer
// ----------------------------------------------------------------------------
package mwm_pkg;

  // field widths
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned NUM_WHEELS = 4;

  // mixing datapath widths
  localparam int unsigned FACTOR_W   = 18;
  localparam int unsigned LIN_W      = SPEED_W + 1;
  localparam int unsigned PROD_W     = SPEED_W + FACTOR_W;
  localparam int unsigned Q8_W       = PROD_W + 1;
  localparam int unsigned Q8_LO_W    = 18;
  localparam int unsigned Q8_HI_W    = Q8_W - Q8_LO_W;
  localparam int unsigned PP_LO_W    = Q8_LO_W + COEF_W;
  localparam int unsigned PP_HI_W    = Q8_HI_W + COEF_W;
  localparam int unsigned Q20_W      = Q8_W + COEF_W;
  localparam int unsigned FRAC_SHIFT = 20;
  localparam int unsigned TRUNC_W    = Q20_W - FRAC_SHIFT;
  localparam int unsigned LIN_SHIFT  = 8;

  // scaling divider widths
  localparam int unsigned MAG_W      = SPEED_W;
  localparam int unsigned NUM_W      = MAG_W + LIMIT_W;
  localparam int unsigned QUOT_W     = LIMIT_W;
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_STAGES = QUOT_W / DIV_STEPS;

  // pipeline and queue sizes
  localparam int unsigned FRONT_STAGES = 7;
  localparam int unsigned BACK_STAGES  = DIV_STAGES + 2;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W  = QUEUE_PTR_W + 1;

  // configuration port
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // wheel saturation bounds
  localparam logic signed [SPEED_W-1:0] WHEEL_MAX = 16'sh7fff;
  localparam logic signed [SPEED_W-1:0] WHEEL_MIN = 16'sh8000;

  // register reset values
  localparam logic [COEF_W-1:0]  ROTATE_BASE_RST = 16'd1792;
  localparam logic [COEF_W-1:0]  RPM_RATIO_RST   = 16'd4096;
  localparam logic [LIMIT_W-1:0] MAX_X_RST       = 15'd3500;
  localparam logic [LIMIT_W-1:0] MAX_Y_RST       = 15'd3500;
  localparam logic [LIMIT_W-1:0] MAX_W_RST       = 15'd600;
  localparam logic [LIMIT_W-1:0] MAX_WHEEL_RST   = 15'd8500;

  // register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROTATE_BASE,
    REG_GIMBAL_X,
    REG_GIMBAL_Y,
    REG_RPM_RATIO,
    REG_MAX_SPEED_X,
    REG_MAX_SPEED_Y,
    REG_MAX_SPEED_W,
    REG_MAX_WHEEL
  } mwm_reg_e;

  // configuration register set
  typedef struct packed {
    logic        [COEF_W-1:0]  rotate_base;
    logic signed [COEF_W-1:0]  gimbal_x_term;
    logic signed [COEF_W-1:0]  gimbal_y_term;
    logic        [COEF_W-1:0]  rpm_ratio;
    logic        [LIMIT_W-1:0] max_speed_x;
    logic        [LIMIT_W-1:0] max_speed_y;
    logic        [LIMIT_W-1:0] max_speed_w;
    logic        [LIMIT_W-1:0] max_wheel_speed;
  } mwm_cfg_t;

  // classified word passed from the front to the back
  typedef struct packed {
    logic [NUM_WHEELS-1:0][SPEED_W-1:0] wheel;
    logic [MAG_W-1:0]                   largest;
    logic [LIMIT_W-1:0]                 limit;
    logic                               scaled;
  } mwm_item_t;

endpackage

[rtl/core/mwm_front.sv]
// ----------------------------------------------------------------------------
// mwm_front
// clamps the command, mixes four wheel speeds, applies the rpm ratio,
// saturates and marks words whose peak wheel needs proportional scaling
// ----------------------------------------------------------------------------
module mwm_front (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  mwm_pkg::mwm_cfg_t                        cfg_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic signed [mwm_pkg::SPEED_W-1:0]       speed_x_i,
  input  logic signed [mwm_pkg::SPEED_W-1:0]       speed_y_i,
  input  logic signed [mwm_pkg::SPEED_W-1:0]       speed_w_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output mwm_pkg::mwm_item_t                       out_item_o,
  output logic                                     busy_o
);

  localparam int unsigned NW = mwm_pkg::NUM_WHEELS;
  localparam int unsigned NS = mwm_pkg::FRONT_STAGES;

  // stage positions
  localparam int unsigned ST_CLAMP = 0;
  localparam int unsigned ST_MIX   = 1;
  localparam int unsigned ST_Q8    = 2;
  localparam int unsigned ST_PP    = 3;
  localparam int unsigned ST_Q20   = 4;
  localparam int unsigned ST_SAT   = 5;
  localparam int unsigned ST_PEAK  = 6;

  localparam logic [mwm_pkg::Q20_W-1:0] ROUND_BIAS =
    (mwm_pkg::Q20_W'(1) << mwm_pkg::FRAC_SHIFT) - mwm_pkg::Q20_W'(1);

  // magnitude clamp against an unsigned limit
  function automatic logic signed [mwm_pkg::SPEED_W-1:0] clamp_mag(
    input logic signed [mwm_pkg::SPEED_W-1:0] v,
    input logic        [mwm_pkg::LIMIT_W-1:0] lim
  );
    logic signed [mwm_pkg::SPEED_W:0] v_ext;
    logic signed [mwm_pkg::SPEED_W:0] hi;
    logic signed [mwm_pkg::SPEED_W:0] lo;
    logic signed [mwm_pkg::SPEED_W:0] res;
    v_ext = (mwm_pkg::SPEED_W + 1)'(v);
    hi    = $signed({2'b00, lim});
    lo    = -hi;
    if (v_ext > hi) begin
      res = hi;
    end else if (v_ext < lo) begin
      res = lo;
    end else begin
      res = v_ext;
    end
    return res[mwm_pkg::SPEED_W-1:0];
  endfunction

  logic [NS-1:0] v_q;
  logic [NS:0]   adv;

  logic signed [mwm_pkg::FACTOR_W-1:0] fac [NW];
  logic signed [mwm_pkg::FACTOR_W-1:0] base_ext;
  logic signed [mwm_pkg::FACTOR_W-1:0] gx_ext;
  logic signed [mwm_pkg::FACTOR_W-1:0] gy_ext;

  logic signed [mwm_pkg::SPEED_W-1:0] s0_vx_q;
  logic signed [mwm_pkg::SPEED_W-1:0] s0_vy_q;
  logic signed [mwm_pkg::SPEED_W-1:0] s0_vw_q;

  logic signed [mwm_pkg::LIN_W-1:0]   lin_d   [NW];
  logic signed [mwm_pkg::LIN_W-1:0]   s1_lin_q  [NW];
  logic signed [mwm_pkg::PROD_W-1:0]  s1_prod_q [NW];
  logic signed [mwm_pkg::Q8_W-1:0]    s2_q8_q   [NW];
  logic        [mwm_pkg::PP_LO_W-1:0] s3_pplo_q [NW];
  logic signed [mwm_pkg::PP_HI_W-1:0] s3_pphi_q [NW];
  logic signed [mwm_pkg::Q20_W-1:0]   s4_q20_q  [NW];

  logic signed [mwm_pkg::Q20_W-1:0]   biased  [NW];
  logic signed [mwm_pkg::TRUNC_W-1:0] trunc_v [NW];
  logic signed [mwm_pkg::SPEED_W-1:0] sat_d   [NW];
  logic signed [mwm_pkg::SPEED_W-1:0] s5_w_q  [NW];

  logic [mwm_pkg::MAG_W-1:0] mag [NW];
  logic [mwm_pkg::MAG_W-1:0] peak_01;
  logic [mwm_pkg::MAG_W-1:0] peak_23;
  logic [mwm_pkg::MAG_W-1:0] peak_d;
  mwm_pkg::mwm_item_t        s6_item_q;

  // stall chain: a stage loads when it is empty or its successor moves
  always_comb begin
    adv[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];
  assign out_item_o  = s6_item_q;
  assign busy_o      = |v_q;

  // per-wheel rotation factors, base plus or minus the gimbal terms
  always_comb begin
    base_ext = $signed({2'b00, cfg_i.rotate_base});
    gx_ext   = mwm_pkg::FACTOR_W'(cfg_i.gimbal_x_term);
    gy_ext   = mwm_pkg::FACTOR_W'(cfg_i.gimbal_y_term);
    fac[0]   = base_ext - gx_ext + gy_ext;
    fac[1]   = base_ext - gx_ext - gy_ext;
    fac[2]   = base_ext + gx_ext + gy_ext;
    fac[3]   = base_ext + gx_ext - gy_ext;
  end

  // clamp stage
  always_ff @(posedge clk_i) begin
    if (adv[ST_CLAMP]) begin
      s0_vx_q <= clamp_mag(speed_x_i, cfg_i.max_speed_x);
      s0_vy_q <= clamp_mag(speed_y_i, cfg_i.max_speed_y);
      s0_vw_q <= clamp_mag(speed_w_i, cfg_i.max_speed_w);
    end
  end

  // linear terms of each wheel
  always_comb begin
    lin_d[0] = -mwm_pkg::LIN_W'(s0_vx_q) - mwm_pkg::LIN_W'(s0_vy_q);
    lin_d[1] =  mwm_pkg::LIN_W'(s0_vx_q) - mwm_pkg::LIN_W'(s0_vy_q);
    lin_d[2] = -mwm_pkg::LIN_W'(s0_vx_q) + mwm_pkg::LIN_W'(s0_vy_q);
    lin_d[3] =  mwm_pkg::LIN_W'(s0_vx_q) + mwm_pkg::LIN_W'(s0_vy_q);
  end

  // rotation product
  always_ff @(posedge clk_i) begin
    if (adv[ST_MIX]) begin
      for (int i = 0; i < NW; i++) begin
        s1_lin_q[i]  <= lin_d[i];
        s1_prod_q[i] <= s0_vw_q * fac[i];
      end
    end
  end

  // q8 wheel value
  always_ff @(posedge clk_i) begin
    if (adv[ST_Q8]) begin
      for (int i = 0; i < NW; i++) begin
        s2_q8_q[i] <= (mwm_pkg::Q8_W'(s1_lin_q[i]) <<< mwm_pkg::LIN_SHIFT)
                      + mwm_pkg::Q8_W'(s1_prod_q[i]);
      end
    end
  end

  // rpm ratio as two partial products
  always_ff @(posedge clk_i) begin
    if (adv[ST_PP]) begin
      for (int i = 0; i < NW; i++) begin
        s3_pplo_q[i] <= mwm_pkg::PP_LO_W'(s2_q8_q[i][mwm_pkg::Q8_LO_W-1:0])
                        * mwm_pkg::PP_LO_W'(cfg_i.rpm_ratio);
        s3_pphi_q[i] <= $signed(s2_q8_q[i][mwm_pkg::Q8_W-1:mwm_pkg::Q8_LO_W])
                        * $signed({1'b0, cfg_i.rpm_ratio});
      end
    end
  end

  // recombine into the q20 value
  always_ff @(posedge clk_i) begin
    if (adv[ST_Q20]) begin
      for (int i = 0; i < NW; i++) begin
        s4_q20_q[i] <= (mwm_pkg::Q20_W'(s3_pphi_q[i]) <<< mwm_pkg::Q8_LO_W)
                       + $signed({{(mwm_pkg::Q20_W - mwm_pkg::PP_LO_W){1'b0}},
                                  s3_pplo_q[i]});
      end
    end
  end

  // truncate toward zero and saturate to int16
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      biased[i]  = s4_q20_q[i]
                   + $signed(s4_q20_q[i][mwm_pkg::Q20_W-1] ? ROUND_BIAS : '0);
      trunc_v[i] = mwm_pkg::TRUNC_W'(biased[i] >>> mwm_pkg::FRAC_SHIFT);
      if (trunc_v[i] > mwm_pkg::TRUNC_W'(mwm_pkg::WHEEL_MAX)) begin
        sat_d[i] = mwm_pkg::WHEEL_MAX;
      end else if (trunc_v[i] < mwm_pkg::TRUNC_W'(mwm_pkg::WHEEL_MIN)) begin
        sat_d[i] = mwm_pkg::WHEEL_MIN;
      end else begin
        sat_d[i] = trunc_v[i][mwm_pkg::SPEED_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_SAT]) begin
      for (int i = 0; i < NW; i++) begin
        s5_w_q[i] <= sat_d[i];
      end
    end
  end

  // peak magnitude and scaling decision
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      mag[i] = s5_w_q[i][mwm_pkg::SPEED_W-1] ? mwm_pkg::MAG_W'(-s5_w_q[i])
                                               : mwm_pkg::MAG_W'(s5_w_q[i]);
    end
    peak_01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
    peak_23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
    peak_d  = (peak_01 > peak_23) ? peak_01 : peak_23;
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_PEAK]) begin
      for (int i = 0; i < NW; i++) begin
        s6_item_q.wheel[i] <= s5_w_q[i];
      end
      s6_item_q.largest <= peak_d;
      s6_item_q.limit   <= cfg_i.max_wheel_speed;
      s6_item_q.scaled  <= peak_d > mwm_pkg::MAG_W'(cfg_i.max_wheel_speed);
    end
  end

endmodule

[rtl/core/mwm_queue.sv]
// ----------------------------------------------------------------------------
// mwm_queue
// short first-in first-out buffer between the front and the back
// ----------------------------------------------------------------------------
module mwm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mwm_pkg::mwm_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mwm_pkg::mwm_item_t out_item_o
);

  mwm_pkg::mwm_item_t                 mem_q [mwm_pkg::QUEUE_DEPTH];
  logic [mwm_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
  logic [mwm_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
  logic [mwm_pkg::QUEUE_CNT_W-1:0]    cnt_q;
  logic [mwm_pkg::QUEUE_CNT_W-1:0]    cnt_d;
  logic                               push;
  logic                               pop;

  // fill status
  assign in_ready_o  = cnt_q != mwm_pkg::QUEUE_CNT_W'(mwm_pkg::QUEUE_DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

[rtl/core/mwm_back.sv]
// ----------------------------------------------------------------------------
// mwm_back
// proportional scaling of flagged words: |wheel| * limit / largest in a
// pipelined restoring divider, one lane per wheel, then the output register
// ----------------------------------------------------------------------------
module mwm_back (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                in_valid_i,
  output logic                                                in_ready_o,
  input  mwm_pkg::mwm_item_t                                  in_item_i,
  output logic                                                out_valid_o,
  input  logic                                                out_ready_i,
  output logic [mwm_pkg::NUM_WHEELS-1:0][mwm_pkg::SPEED_W-1:0] wheel_o,
  output logic                                                scaled_o,
  output logic                                                busy_o
);

  localparam int unsigned NW     = mwm_pkg::NUM_WHEELS;
  localparam int unsigned NS     = mwm_pkg::BACK_STAGES;
  localparam int unsigned ND     = mwm_pkg::DIV_STAGES;
  localparam int unsigned ST_MUL = 0;
  localparam int unsigned ST_OUT = NS - 1;

  // a few restoring division steps; quotient bits shift in at the bottom
  function automatic logic [mwm_pkg::NUM_W-1:0] div_steps(
    input logic [mwm_pkg::NUM_W-1:0] acc,
    input logic [mwm_pkg::MAG_W-1:0] d
  );
    logic [mwm_pkg::NUM_W-1:0] a;
    logic [mwm_pkg::MAG_W:0]   r2;
    logic [mwm_pkg::MAG_W:0]   diff;
    a = acc;
    for (int k = 0; k < mwm_pkg::DIV_STEPS; k++) begin
      r2   = {a[mwm_pkg::NUM_W-1:mwm_pkg::QUOT_W], a[mwm_pkg::QUOT_W-1]};
      diff = r2 - {1'b0, d};
      if (r2 >= {1'b0, d}) begin
        a = {diff[mwm_pkg::MAG_W-1:0], a[mwm_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        a = {r2[mwm_pkg::MAG_W-1:0], a[mwm_pkg::QUOT_W-2:0], 1'b0};
      end
    end
    return a;
  endfunction

  logic [NS-1:0] v_q;
  logic [NS:0]   adv;

  logic [mwm_pkg::MAG_W-1:0]   mag_in [NW];

  logic [mwm_pkg::NUM_W-1:0]   b0_acc_q [NW];
  logic [mwm_pkg::SPEED_W-1:0] b0_w_q   [NW];
  logic [mwm_pkg::MAG_W-1:0]   b0_d_q;
  logic                        b0_scaled_q;

  logic [mwm_pkg::NUM_W-1:0]   dv_acc_q    [ND][NW];
  logic [mwm_pkg::SPEED_W-1:0] dv_w_q      [ND][NW];
  logic [mwm_pkg::MAG_W-1:0]   dv_d_q      [ND];
  logic                        dv_scaled_q [ND];

  logic [mwm_pkg::SPEED_W-1:0] quot_d [NW];
  logic [mwm_pkg::SPEED_W-1:0] res_d  [NW];
  logic [NW-1:0][mwm_pkg::SPEED_W-1:0] out_w_q;
  logic                        out_scaled_q;

  // stall chain, the last stage waits on the output handshake
  always_comb begin
    adv[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];
  assign wheel_o     = out_w_q;
  assign scaled_o    = out_scaled_q;
  assign busy_o      = |v_q;

  // dividend: wheel magnitude times the wheel limit
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      mag_in[i] = in_item_i.wheel[i][mwm_pkg::SPEED_W-1]
                  ? mwm_pkg::MAG_W'(-in_item_i.wheel[i])
                  : mwm_pkg::MAG_W'(in_item_i.wheel[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_MUL]) begin
      for (int i = 0; i < NW; i++) begin
        b0_acc_q[i] <= mwm_pkg::NUM_W'(mag_in[i]) * mwm_pkg::NUM_W'(in_item_i.limit);
        b0_w_q[i]   <= in_item_i.wheel[i];
      end
      b0_d_q      <= in_item_i.largest;
      b0_scaled_q <= in_item_i.scaled;
    end
  end

  // divider stages
  for (genvar s = 0; s < ND; s++) begin : g_div
    logic [mwm_pkg::NUM_W-1:0]   acc_src [NW];
    logic [mwm_pkg::SPEED_W-1:0] w_src   [NW];
    logic [mwm_pkg::MAG_W-1:0]   d_src;
    logic                        sc_src;

    if (s == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < NW; i++) begin
          acc_src[i] = b0_acc_q[i];
          w_src[i]   = b0_w_q[i];
        end
        d_src  = b0_d_q;
        sc_src = b0_scaled_q;
      end
    end else begin : g_next
      always_comb begin
        for (int i = 0; i < NW; i++) begin
          acc_src[i] = dv_acc_q[s-1][i];
          w_src[i]   = dv_w_q[s-1][i];
        end
        d_src  = dv_d_q[s-1];
        sc_src = dv_scaled_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s+1]) begin
        for (int i = 0; i < NW; i++) begin
          dv_acc_q[s][i] <= div_steps(acc_src[i], d_src);
          dv_w_q[s][i]   <= w_src[i];
        end
        dv_d_q[s]      <= d_src;
        dv_scaled_q[s] <= sc_src;
      end
    end
  end

  // restore sign, or pass the wheel through when no scaling applies
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      quot_d[i] = {1'b0, dv_acc_q[ND-1][i][mwm_pkg::QUOT_W-1:0]};
      if (!dv_scaled_q[ND-1]) begin
        res_d[i] = dv_w_q[ND-1][i];
      end else if (dv_w_q[ND-1][i][mwm_pkg::SPEED_W-1]) begin
        res_d[i] = -quot_d[i];
      end else begin
        res_d[i] = quot_d[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv[ST_OUT]) begin
      for (int i = 0; i < NW; i++) begin
        out_w_q[i] <= res_d[i];
      end
      out_scaled_q <= dv_scaled_q[ND-1];
    end
  end

endmodule

[rtl/core/mecanum_wheel_mixer.sv]
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer: four-wheel mecanum mixing with per-wheel limits
// throughput: one word per clock while m_axis_tready holds; a taken input word
// passes 7 mixing stages with a split rpm multiply, the 4-entry queue, 1 scale
// stage, 5 divider stages of 3 quotient bits and 1 output register before tvalid
// reset: rst_ni async active low clears pipeline valids and the queue and loads
// register defaults; no clearing pass, input is taken right after reset
// ----------------------------------------------------------------------------
`include "mecanum_wheel_mixer_macros.svh"

module mecanum_wheel_mixer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mwm_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  logic [mwm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // command stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [47:0]                     s_axis_tdata,  // speed_x, speed_y, speed_w
  // wheel stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [63:0]                     m_axis_tdata,  // wheel_0, wheel_1, wheel_2, wheel_3
  output logic                            m_axis_tuser   // was_scaled
);

  localparam int unsigned SW = mwm_pkg::SPEED_W;

  mwm_pkg::mwm_cfg_t  cfg_q;
  mwm_pkg::mwm_item_t f_item;
  mwm_pkg::mwm_item_t q_item;
  logic               f_valid;
  logic               q_in_ready;
  logic               q_out_valid;
  logic               q_out_ready;
  logic               front_busy;
  logic               back_busy;
  logic [mwm_pkg::NUM_WHEELS-1:0][SW-1:0] out_wheel;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotate_base     <= mwm_pkg::ROTATE_BASE_RST;
      cfg_q.gimbal_x_term   <= '0;
      cfg_q.gimbal_y_term   <= '0;
      cfg_q.rpm_ratio       <= mwm_pkg::RPM_RATIO_RST;
      cfg_q.max_speed_x     <= mwm_pkg::MAX_X_RST;
      cfg_q.max_speed_y     <= mwm_pkg::MAX_Y_RST;
      cfg_q.max_speed_w     <= mwm_pkg::MAX_W_RST;
      cfg_q.max_wheel_speed <= mwm_pkg::MAX_WHEEL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mwm_pkg::mwm_reg_e'(cfg_index_i))
        mwm_pkg::REG_ROTATE_BASE: begin
          cfg_q.rotate_base <= cfg_data_i;
        end
        mwm_pkg::REG_GIMBAL_X: begin
          cfg_q.gimbal_x_term <= $signed(cfg_data_i);
        end
        mwm_pkg::REG_GIMBAL_Y: begin
          cfg_q.gimbal_y_term <= $signed(cfg_data_i);
        end
        mwm_pkg::REG_RPM_RATIO: begin
          cfg_q.rpm_ratio <= cfg_data_i;
        end
        mwm_pkg::REG_MAX_SPEED_X: begin
          cfg_q.max_speed_x <= cfg_data_i[mwm_pkg::LIMIT_W-1:0];
        end
        mwm_pkg::REG_MAX_SPEED_Y: begin
          cfg_q.max_speed_y <= cfg_data_i[mwm_pkg::LIMIT_W-1:0];
        end
        mwm_pkg::REG_MAX_SPEED_W: begin
          cfg_q.max_speed_w <= cfg_data_i[mwm_pkg::LIMIT_W-1:0];
        end
        mwm_pkg::REG_MAX_WHEEL: begin
          cfg_q.max_wheel_speed <= cfg_data_i[mwm_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // mixing front
  mwm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .speed_x_i   ($signed(s_axis_tdata[SW-1:0])),
    .speed_y_i   ($signed(s_axis_tdata[2*SW-1:SW])),
    .speed_w_i   ($signed(s_axis_tdata[3*SW-1:2*SW])),
    .out_valid_o (f_valid),
    .out_ready_i (q_in_ready),
    .out_item_o  (f_item),
    .busy_o      (front_busy)
  );

  // decoupling queue
  mwm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (q_in_ready),
    .in_item_i   (f_item),
    .out_valid_o (q_out_valid),
    .out_ready_i (q_out_ready),
    .out_item_o  (q_item)
  );

  // scaling back
  mwm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_out_valid),
    .in_ready_o  (q_out_ready),
    .in_item_i   (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .wheel_o     (out_wheel),
    .scaled_o    (m_axis_tuser),
    .busy_o      (back_busy)
  );

  assign m_axis_tdata = out_wheel;

  // checks
  `MWM_ASSERT_NEXT(a_front_takes_word, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, front_busy, "accepted command word not held in front")
  `MWM_ASSERT_NEXT(a_queue_holds_word, clk_i, rst_ni, f_valid && q_in_ready && !(q_out_valid && q_out_ready), q_out_valid, "pushed word missing from queue")
  `MWM_ASSERT_NEXT(a_back_takes_word, clk_i, rst_ni, q_out_valid && q_out_ready, back_busy, "popped word not held in back")
  `MWM_ASSERT_NOW(a_scaled_below_full, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, (out_wheel[0] != mwm_pkg::WHEEL_MIN) && (out_wheel[1] != mwm_pkg::WHEEL_MIN) && (out_wheel[2] != mwm_pkg::WHEEL_MIN) && (out_wheel[3] != mwm_pkg::WHEEL_MIN), "scaled wheel reached negative full scale")

endmodule
